// ===== src/cldq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the circular list deque engine.
// Used by the controller, the datapath, the top level and the checker.
package cldq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_READ_ALL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SHIFT,
    S_READ,
    S_EMIT_OK,
    S_EMIT_FULL,
    S_EMIT_EMPTY,
    S_EMIT_NOTFOUND
  } ctl_state_e;

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [DATA_W-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  entry_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    rd_first;
    logic    rd_next;
    logic    ins_front;
    logic    ins_back;
    logic    shift_wr;
    logic    mark_gap;
    logic    occ_dec;
    logic    out_load;
    status_e out_status;
    logic    out_from_rd;
    logic    out_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic match;
    logic at_end;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/cldq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the circular list deque engine.
// Depends on cldq_pkg; drives the datapath through dp_cmd_t.
module cldq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cldq_pkg::dp_sts_t sts_i,
  output cldq_pkg::dp_cmd_t cmd_o
);
  import cldq_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.out_status  = ST_OK;
    in_stall_o        = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.cmd)
          CMD_INS_FRONT, CMD_INS_BACK: begin
            if (sts_i.full) begin
              state_d = S_EMIT_FULL;
            end else begin
              cmd_o.ins_front = (sts_i.cmd == CMD_INS_FRONT);
              cmd_o.ins_back  = (sts_i.cmd == CMD_INS_BACK);
              state_d         = S_EMIT_OK;
            end
          end
          CMD_DELETE: begin
            if (sts_i.empty) begin
              state_d = S_EMIT_EMPTY;
            end else begin
              cmd_o.rd_first = 1'b1;
              state_d        = S_SEARCH;
            end
          end
          CMD_READ_ALL: begin
            if (sts_i.empty) begin
              state_d = S_EMIT_EMPTY;
            end else begin
              cmd_o.rd_first = 1'b1;
              state_d        = S_READ;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        if (sts_i.match) begin
          if (sts_i.at_end) begin
            cmd_o.occ_dec = 1'b1;
            state_d       = S_EMIT_OK;
          end else begin
            cmd_o.mark_gap = 1'b1;
            cmd_o.rd_next  = 1'b1;
            state_d        = S_SHIFT;
          end
        end else if (sts_i.at_end) begin
          state_d = S_EMIT_NOTFOUND;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.at_end) begin
          cmd_o.occ_dec = 1'b1;
          state_d       = S_EMIT_OK;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.out_from_rd = 1'b1;
          cmd_o.out_last    = sts_i.at_end;
          if (sts_i.at_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_EMIT_OK, S_EMIT_FULL, S_EMIT_EMPTY, S_EMIT_NOTFOUND: begin
        case (state_q)
          S_EMIT_FULL:     cmd_o.out_status = ST_FULL;
          S_EMIT_EMPTY:    cmd_o.out_status = ST_EMPTY;
          S_EMIT_NOTFOUND: cmd_o.out_status = ST_NOTFOUND;
          default:         cmd_o.out_status = ST_OK;
        endcase
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== src/cldq_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: entry memory, ring pointers, scan counter and output register.
// Depends on cldq_pkg; steered by cldq_ctrl through dp_cmd_t.
module cldq_datapath #(
  parameter int unsigned CAPACITY = cldq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cldq_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output cldq_pkg::out_item_t out_item_o,
  input  cldq_pkg::dp_cmd_t   cmd_i,
  output cldq_pkg::dp_sts_t   sts_o
);
  import cldq_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = IW + 1;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

  function automatic logic [IW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= CAP_S) ? s - CAP_S : s;
    return r[IW-1:0];
  endfunction

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;
  logic [IW-1:0]            rd_slot_q;
  logic [IW-1:0]            gap_q;
  logic signed [DATA_W-1:0] val_q;
  cmd_e                     cmd_q;

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [CW-1:0] p_q, p_d;
  logic [CW-1:0] p_nxt;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] back_slot;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign p_nxt     = p_q + 1'b1;
  assign front_dec = (front_q == '0) ? LAST_I : front_q - 1'b1;
  assign back_slot = wrap({1'b0, front_q} + SW'(occ_q));
  assign rd_en     = cmd_i.rd_first | cmd_i.rd_next;
  assign rd_addr   = cmd_i.rd_first ? front_q : wrap({1'b0, front_q} + SW'(p_nxt));

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = back_slot;
    wr_data = val_q;
    if (cmd_i.ins_front) begin
      wr_addr = front_dec;
    end else if (cmd_i.shift_wr) begin
      wr_addr = gap_q;
      wr_data = rd_data_q;
    end else if (!cmd_i.ins_back) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_slot_q <= rd_addr;
    end
    if (cmd_i.shift_wr || cmd_i.mark_gap) begin
      gap_q <= rd_slot_q;
    end
    if (cmd_i.capture) begin
      cmd_q <= in_item_i.cmd;
      val_q <= in_item_i.item_value;
    end
    if (cmd_i.out_load) begin
      out_item_q.status      <= cmd_i.out_status;
      out_item_q.entry_value <= cmd_i.out_from_rd ? rd_data_q : '0;
      out_item_q.entry_count <= COUNT_W'(occ_q);
      out_item_q.last        <= cmd_i.out_last;
    end
  end

  always_comb begin
    front_d     = front_q;
    occ_d       = occ_q;
    p_d         = p_q;
    out_valid_d = out_valid_q;
    if (cmd_i.ins_front) begin
      front_d = front_dec;
    end
    if (cmd_i.ins_front || cmd_i.ins_back) begin
      occ_d = occ_q + 1'b1;
    end else if (cmd_i.occ_dec) begin
      occ_d = occ_q - 1'b1;
    end
    if (cmd_i.rd_first) begin
      p_d = '0;
    end else if (cmd_i.rd_next) begin
      p_d = p_nxt;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      occ_q       <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      occ_q       <= occ_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.full     = (occ_q == CAP_C);
  assign sts_o.empty    = (occ_q == '0);
  assign sts_o.match    = (rd_data_q == val_q);
  assign sts_o.at_end   = (p_nxt == occ_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/circular_list_deque_engine.sv =====
`timescale 1ns / 1ps
// Top level of the circular list deque engine: controller plus datapath.
// Depends on cldq_pkg, cldq_ctrl and cldq_datapath.
//
// Ordered ring of up to CAPACITY signed 32-bit entries in a single memory
// with a registered read port. One command is handled at a time; the next
// is taken as soon as the previous one has handed its last result to the
// output register, even while that result is still stalled. A delete walks
// the memory one entry a cycle from the front to the match, then moves every
// later entry up one place, again one a cycle, so each held entry is visited
// once. A read gives one result a cycle while the output is not stalled.
// The single memory read port, stepped at most once per cycle, sets this pace.
// No clearing pass is needed after reset.
module circular_list_deque_engine #(
  parameter int unsigned CAPACITY = cldq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cldq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cldq_pkg::out_item_t out_item_o
);
  import cldq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  cldq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  cldq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

endmodule

// ===== src/cldq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the circular list deque engine, bound to the top.
// Depends on cldq_pkg.
module cldq_checker #(
  parameter int unsigned CAPACITY = cldq_pkg::CAPACITY_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input cldq_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cldq_pkg::out_item_t out_item_o
);
  import cldq_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one command in flight at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer taken while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_FULL |->
      out_item_o.entry_count == CAP_CNT && out_item_o.last)
    else $error("full status with wrong count");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_EMPTY |->
      out_item_o.entry_count == '0 && out_item_o.entry_value == '0 && out_item_o.last)
    else $error("empty status with entries");

endmodule

bind circular_list_deque_engine cldq_checker #(.CAPACITY(CAPACITY)) u_cldq_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_list_deque_engine: queued driver, monitor and
// a ring-buffer predictor of inserts, deletes and read-outs. Depends on cldq_pkg.
module testbench;
  import cldq_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int DRAIN_WAIT = 4 * CAP + 16;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  in_item_t  in_item     = '0;
  logic      out_stall   = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];

  logic signed [DATA_W-1:0] ring_entries[CAP];
  int ring_front = 0;
  int ring_held  = 0;

  int send_idle_pct = 29;
  int recv_idle_pct = 52;
  int deque_mismatches = 0;

  circular_list_deque_engine #(.CAPACITY(CAP)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic predict_command(input in_item_t it);
    out_item_t r;
    int hit;
    r = '0;
    r.last = 1'b1;
    case (it.cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (ring_held >= CAP) begin
          r.status = ST_FULL;
        end else if (it.cmd == CMD_INS_FRONT) begin
          ring_front = (ring_front + CAP - 1) % CAP;
          ring_entries[ring_front] = it.item_value;
          ring_held++;
        end else begin
          ring_entries[(ring_front + ring_held) % CAP] = it.item_value;
          ring_held++;
        end
        r.entry_count = COUNT_W'(ring_held);
        expected_results.push_back(r);
      end
      CMD_DELETE: begin
        if (ring_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < ring_held && hit < 0; i++)
            if (ring_entries[(ring_front + i) % CAP] == it.item_value) hit = i;
          if (hit < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int i = hit; i + 1 < ring_held; i++)
              ring_entries[(ring_front + i) % CAP] = ring_entries[(ring_front + i + 1) % CAP];
            ring_held--;
          end
        end
        r.entry_count = COUNT_W'(ring_held);
        expected_results.push_back(r);
      end
      default: begin
        r.entry_count = COUNT_W'(ring_held);
        if (ring_held == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < ring_held; i++) begin
            r.status      = ST_OK;
            r.entry_value = ring_entries[(ring_front + i) % CAP];
            r.last        = (i == ring_held - 1);
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // Driver: hold the payload while stalled, advance after each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    logic take;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      take = in_valid && !in_stall_o;
      if (take) predict_command(in_item);
      if (!in_valid || take) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (deque_mismatches < 10)
            $display("%0t: unexpected result status=%0d value=%0d count=%0d last=%0b",
                     $realtime, out_item_o.status, out_item_o.entry_value,
                     out_item_o.entry_count, out_item_o.last);
          deque_mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.status !== want.status || out_item_o.entry_value !== want.entry_value ||
              out_item_o.entry_count !== want.entry_count || out_item_o.last !== want.last) begin
            if (deque_mismatches < 10)
              $display("%0t: mismatch exp st=%0d val=%0d cnt=%0d last=%0b / got st=%0d val=%0d cnt=%0d last=%0b",
                       $realtime, want.status, want.entry_value, want.entry_count, want.last,
                       out_item_o.status, out_item_o.entry_value, out_item_o.entry_count,
                       out_item_o.last);
            deque_mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_cmd(input cmd_e c, input logic signed [DATA_W-1:0] v);
    in_item_t it;
    it.cmd        = c;
    it.item_value = v;
    pending_cmds.push_back(it);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(99) >= 70) return $signed($urandom);
    case ($urandom_range(7))
      0: return 32'sh0000_0000;
      1: return 32'sh0000_0001;
      2: return -32'sd1;
      3: return 32'sh8000_0000;
      4: return 32'sh7fff_ffff;
      5: return 32'sh5a5a_5a5a;
      6: return 32'sh0000_8000;
      default: return 32'sh0000_0007;
    endcase
  endfunction

  // Bursts lean towards filling, draining or an even mix.
  task automatic queue_random(input int n);
    int mode;
    int pick;
    cmd_e c;
    mode = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 24 == 0) mode = $urandom_range(2);
      pick = $urandom_range(99);
      case (mode)
        0: c = (pick < 75) ? (pick[0] ? CMD_INS_FRONT : CMD_INS_BACK) :
               (pick < 90) ? CMD_DELETE : CMD_READ_ALL;
        1: c = (pick < 70) ? CMD_DELETE :
               (pick < 85) ? (pick[0] ? CMD_INS_FRONT : CMD_INS_BACK) : CMD_READ_ALL;
        default: c = cmd_e'(pick % 4);
      endcase
      queue_cmd(c, pick_value());
    end
  endtask

  task automatic wait_accepted();
    while (pending_cmds.size() != 0 || in_valid) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_cmd(CMD_READ_ALL, 32'sh0);
    queue_cmd(CMD_DELETE, 32'sd5);
    queue_cmd(CMD_INS_FRONT, 32'sh8000_0000);
    queue_cmd(CMD_INS_BACK, 32'sh7fff_ffff);
    for (int k = 0; k < CAP - 2; k++)
      queue_cmd((k % 2) ? CMD_INS_FRONT : CMD_INS_BACK, k % 5);
    queue_cmd(CMD_INS_BACK, -32'sd1);
    queue_cmd(CMD_READ_ALL, 32'sh0);
    queue_cmd(CMD_DELETE, 32'sd77);
    queue_cmd(CMD_DELETE, 32'sd2);
    queue_cmd(CMD_DELETE, 32'sh7fff_ffff);
    queue_cmd(CMD_READ_ALL, 32'sh0);

    // Hold off until every pending result has been collected.
    wait_accepted();
    while (expected_results.size() != 0) @(negedge clk_i);

    queue_random(170);
    wait_accepted();
    send_idle_pct = 52;
    recv_idle_pct = 29;
    queue_random(170);
    wait_accepted();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(160);
    wait_accepted();

    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (expected_results.size() != 0) deque_mismatches++;
    if (deque_mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
src/cldq_pkg.sv
src/cldq_ctrl.sv
src/cldq_datapath.sv
src/circular_list_deque_engine.sv
src/cldq_checker.sv
dv/testbench.sv
